// ===== rtl/keypad_lock_door_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Keypad lock assertion macros
// Shared concurrent assertion forms for the keypad lock checkers.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_LOCK_DOOR_CONTROLLER_MACROS_SVH
`define KEYPAD_LOCK_DOOR_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KLDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad lock check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KLDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad lock check failed");

`endif

// ===== rtl/kldc_pkg.sv =====
// ----------------------------------------------------------------------------
// Keypad lock package
// Event, motor, status and mode codes plus the result type of the lock.
// ----------------------------------------------------------------------------
package kldc_pkg;

  localparam int CODE_LEN_DEF  = 5;
  localparam int NUM_CODE_REGS = 5;

  localparam int KEY_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int MOTOR_W = 2;
  localparam int STAT_W  = 3;
  localparam int TRIES_W = 4;
  localparam int KEYS_W  = 3;
  localparam int MODE_W  = 2;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 8;
  localparam int IN_D_W  = 8;
  localparam int OUT_D_W = 16;

  localparam logic [KEY_W-1:0]   NO_KEY        = 8'hff;
  localparam logic [TRIES_W-1:0] TRY_LIMIT_RST = 4'd2;

  // Event kinds.
  localparam logic [FUNC_W-1:0] FUNC_KEY       = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE_BTN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLOSE_LIM = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_OPEN_LIM  = 2'd3;

  // Motor commands.
  localparam logic [MOTOR_W-1:0] MOTOR_NONE  = 2'd0;
  localparam logic [MOTOR_W-1:0] MOTOR_OPEN  = 2'd1;
  localparam logic [MOTOR_W-1:0] MOTOR_CLOSE = 2'd2;
  localparam logic [MOTOR_W-1:0] MOTOR_STOP  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_KEY     = 3'd0;
  localparam logic [STAT_W-1:0] ST_RIGHT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_WRONG   = 3'd2;
  localparam logic [STAT_W-1:0] ST_LOCKED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLOSING = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLOSED  = 3'd6;
  localparam logic [STAT_W-1:0] ST_OPENED  = 3'd7;

  // Lock modes.
  localparam logic [MODE_W-1:0] MODE_DOOR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENTRY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] REG_TRY_LIMIT = 3'd5;

  typedef struct packed {
    logic [KEYS_W-1:0]  keys_entered;
    logic [TRIES_W-1:0] tries_left;
    logic [STAT_W-1:0]  status;
    logic [MOTOR_W-1:0] motor_cmd;
  } result_t;

endpackage

// ===== rtl/kldc_core.sv =====
// ----------------------------------------------------------------------------
// Keypad lock core
// Lock state, stored code and the next-state logic for one event.
// ----------------------------------------------------------------------------
module kldc_core #(
  parameter int CODE_LEN = kldc_pkg::CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kldc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [kldc_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          evt_take,
  input  logic [kldc_pkg::FUNC_W-1:0]   evt_func,
  input  logic [kldc_pkg::KEY_W-1:0]    evt_key,
  output kldc_pkg::result_t             evt_res
);

  logic [kldc_pkg::KEY_W-1:0]   code_key_r [kldc_pkg::NUM_CODE_REGS];
  logic [kldc_pkg::KEY_W-1:0]   entry_r    [CODE_LEN];
  logic [kldc_pkg::KEY_W-1:0]   entry_nxt  [CODE_LEN];
  logic [CODE_LEN-1:0]          entry_wr;

  logic [kldc_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [kldc_pkg::KEYS_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [kldc_pkg::TRIES_W-1:0] tries_r, tries_nxt;
  logic closed_r, closed_nxt;
  logic opened_r, opened_nxt;
  logic open_seen_r, open_seen_nxt;
  logic closing_r, closing_nxt;
  logic take_key;
  logic code_ok;
  logic [kldc_pkg::MOTOR_W-1:0] motor;
  logic [kldc_pkg::STAT_W-1:0]  status;

  assign take_key = (evt_func == kldc_pkg::FUNC_KEY) && (mode_r == kldc_pkg::MODE_ENTRY) &&
                    (evt_key != kldc_pkg::NO_KEY);
  assign idx_inc  = idx_r + kldc_pkg::KEYS_W'(1);

  // The key being taken is written and compared in the same cycle, so the
  // comparison looks at the entry values as they will be after this event.
  always_comb begin
    code_ok = 1'b1;
    for (int k = 0; k < CODE_LEN; k++) begin
      entry_wr[k]  = take_key && (idx_r == kldc_pkg::KEYS_W'(k));
      entry_nxt[k] = entry_wr[k] ? evt_key : entry_r[k];
      code_ok      = code_ok && (entry_nxt[k] == code_key_r[k]);
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    tries_nxt     = tries_r;
    closed_nxt    = closed_r;
    opened_nxt    = opened_r;
    open_seen_nxt = open_seen_r;
    closing_nxt   = closing_r;
    motor         = kldc_pkg::MOTOR_NONE;
    status        = kldc_pkg::ST_IGNORED;
    case (evt_func)
      kldc_pkg::FUNC_KEY: begin
        if (mode_r == kldc_pkg::MODE_LOCKED) begin
          status = kldc_pkg::ST_LOCKED;
        end else if (take_key) begin
          if (idx_inc < kldc_pkg::KEYS_W'(CODE_LEN)) begin
            idx_nxt = idx_inc;
            status  = kldc_pkg::ST_KEY;
          end else begin
            idx_nxt = '0;
            if (code_ok) begin
              motor      = kldc_pkg::MOTOR_OPEN;
              mode_nxt   = kldc_pkg::MODE_DOOR;
              closed_nxt = 1'b0;
              status     = kldc_pkg::ST_RIGHT;
            end else if (tries_r > kldc_pkg::TRIES_W'(1)) begin
              tries_nxt = tries_r - kldc_pkg::TRIES_W'(1);
              status    = kldc_pkg::ST_WRONG;
            end else begin
              tries_nxt = '0;
              mode_nxt  = kldc_pkg::MODE_LOCKED;
              status    = kldc_pkg::ST_LOCKED;
            end
          end
        end
      end
      kldc_pkg::FUNC_CLOSE_BTN: begin
        if (mode_r == kldc_pkg::MODE_DOOR && !closed_r && opened_r) begin
          motor       = kldc_pkg::MOTOR_CLOSE;
          status      = kldc_pkg::ST_CLOSING;
          opened_nxt  = 1'b0;
          closing_nxt = 1'b1;
        end
      end
      kldc_pkg::FUNC_CLOSE_LIM: begin
        if (open_seen_r && closing_r) begin
          motor         = kldc_pkg::MOTOR_STOP;
          status        = kldc_pkg::ST_CLOSED;
          closed_nxt    = 1'b1;
          mode_nxt      = kldc_pkg::MODE_ENTRY;
          idx_nxt       = '0;
          open_seen_nxt = 1'b0;
          closing_nxt   = 1'b0;
        end
      end
      kldc_pkg::FUNC_OPEN_LIM: begin
        motor         = kldc_pkg::MOTOR_STOP;
        status        = kldc_pkg::ST_OPENED;
        opened_nxt    = 1'b1;
        open_seen_nxt = 1'b1;
      end
      default: begin
        motor = kldc_pkg::MOTOR_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= kldc_pkg::MODE_ENTRY;
      idx_r       <= '0;
      tries_r     <= kldc_pkg::TRY_LIMIT_RST;
      closed_r    <= 1'b0;
      opened_r    <= 1'b0;
      open_seen_r <= 1'b0;
      closing_r   <= 1'b0;
      for (int k = 0; k < kldc_pkg::NUM_CODE_REGS; k++) begin
        code_key_r[k] <= '0;
      end
    end else begin
      if (evt_take) begin
        mode_r      <= mode_nxt;
        idx_r       <= idx_nxt;
        closed_r    <= closed_nxt;
        opened_r    <= opened_nxt;
        open_seen_r <= open_seen_nxt;
        closing_r   <= closing_nxt;
      end
      // Writing the try limit also reloads the remaining tries.
      if (cfg_wr_en && (cfg_addr == kldc_pkg::REG_TRY_LIMIT)) begin
        tries_r <= cfg_wdata[kldc_pkg::TRIES_W-1:0];
      end else if (evt_take) begin
        tries_r <= tries_nxt;
      end
      if (cfg_wr_en) begin
        for (int k = 0; k < kldc_pkg::NUM_CODE_REGS; k++) begin
          if (cfg_addr == kldc_pkg::CFG_A_W'(k)) begin
            code_key_r[k] <= cfg_wdata;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CODE_LEN; k++) begin
      if (evt_take && entry_wr[k]) begin
        entry_r[k] <= evt_key;
      end
    end
  end

  assign evt_res.motor_cmd    = motor;
  assign evt_res.status       = status;
  assign evt_res.tries_left   = tries_nxt;
  assign evt_res.keys_entered = idx_nxt;

endmodule

// ===== rtl/keypad_lock_door_controller.sv =====
// ----------------------------------------------------------------------------
// Keypad lock door controller
// Keypad combination lock with a door motor handshake, one result per event.
// ----------------------------------------------------------------------------
// Each event (key press, close button, close limit or open limit) is taken
// from the input stream and its single result appears in the output register
// on the next cycle. One event is accepted every cycle; in_tready drops only
// while the output register holds a result that the sink has not yet taken,
// so the output register is the only thing that sets the rate.
module keypad_lock_door_controller #(
  parameter int CODE_LEN = kldc_pkg::CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [kldc_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [kldc_pkg::CFG_D_W-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [kldc_pkg::IN_D_W-1:0]   in_tdata,   // [7:0] key_code
  input  logic [kldc_pkg::FUNC_W-1:0]   in_tuser,   // [1:0] func
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] motor_cmd, [4:2] status, [8:5] tries_left, [11:9] keys_entered
  output logic [kldc_pkg::OUT_D_W-1:0]  out_tdata
);

  kldc_pkg::result_t evt_res;
  kldc_pkg::result_t out_res_r;
  logic              out_valid_r;
  logic              in_take;

  assign in_tready = !out_valid_r || out_tready;
  assign in_take   = in_tvalid && in_tready;

  kldc_core #(
    .CODE_LEN (CODE_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .evt_take  (in_take),
    .evt_func  (in_tuser),
    .evt_key   (in_tdata),
    .evt_res   (evt_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res_r <= evt_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.keys_entered, out_res_r.tries_left,
                       out_res_r.status, out_res_r.motor_cmd};

endmodule

// ===== rtl/kldc_checker.sv =====
// ----------------------------------------------------------------------------
// Keypad lock checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "keypad_lock_door_controller_macros.svh"

module kldc_checker #(
  parameter int CODE_LEN = kldc_pkg::CODE_LEN_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [kldc_pkg::OUT_D_W-1:0]  out_tdata
);

  logic [kldc_pkg::MOTOR_W-1:0] motor;
  logic [kldc_pkg::STAT_W-1:0]  status;
  logic [kldc_pkg::KEYS_W-1:0]  keys;
  logic                         out_stall;
  logic                         is_right;
  logic                         is_close;

  assign motor     = out_tdata[1:0];
  assign status    = out_tdata[4:2];
  assign keys      = out_tdata[11:9];
  assign out_stall = out_tvalid && !out_tready;
  assign is_right  = out_tvalid && (status == kldc_pkg::ST_RIGHT);
  assign is_close  = out_tvalid && (motor == kldc_pkg::MOTOR_CLOSE);

  `KLDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))
  `KLDC_ASSERT_NOW(a_right_opens, clk, rst_n, is_right, motor == kldc_pkg::MOTOR_OPEN)
  `KLDC_ASSERT_NOW(a_close_cmd, clk, rst_n, is_close, status == kldc_pkg::ST_CLOSING)
  `KLDC_ASSERT_NOW(a_keys_range, clk, rst_n, out_tvalid, keys < kldc_pkg::KEYS_W'(CODE_LEN))

endmodule

bind keypad_lock_door_controller kldc_checker #(
  .CODE_LEN (CODE_LEN)
) u_kldc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/keypad_lock_door_controller_test.sv =====
// ----------------------------------------------------------------------------
// Keypad lock door controller testbench
// Sends key presses, button and limit switch events through the input stream
// and checks every result against a cycle-free model of the lock kept here.
// Directed checks cover the reset code, code extremes, the door handshake and
// the permanent lock. A long random part runs entry and door sequences with
// noise, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module keypad_lock_door_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import kldc_pkg::*;

  localparam int CODE_LEN     = CODE_LEN_DEF;
  localparam int RANDOM_ITEMS = 1850;

  localparam logic [CFG_A_W-1:0] REG_CODE_KEY0 = '0;

  // Receiver stall styles.
  localparam int STALL_NONE  = 0;
  localparam int STALL_COIN  = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_LONG  = 3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_A_W-1:0]   cfg_addr;
  logic [CFG_D_W-1:0]   cfg_wdata;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_D_W-1:0]    in_tdata;   // [7:0] key_code
  logic [FUNC_W-1:0]    in_tuser;   // [1:0] func
  logic                 out_tvalid;
  logic                 out_tready = 1'b1;
  // [1:0] motor_cmd, [4:2] status, [8:5] tries_left, [11:9] keys_entered
  logic [OUT_D_W-1:0]   out_tdata;

  // Lock model state.
  logic [MODE_W-1:0]    lock_state;
  logic [KEY_W-1:0]     typed_keys [CODE_LEN];
  logic [KEYS_W-1:0]    typed_count;
  logic [TRIES_W-1:0]   tries_avail;
  logic [KEY_W-1:0]     stored_code [NUM_CODE_REGS];
  logic                 closed_seen;
  logic                 opened_seen;
  logic                 open_hit;
  logic                 closing_on;

  result_t              expected_results [$];
  int                   error_count  = 0;
  int                   useful_items = 0;
  int                   burst_left   = 0;
  int                   stall_style  = STALL_NONE;
  int                   stall_left   = 0;

  keypad_lock_door_controller #(
    .CODE_LEN(CODE_LEN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Works out the result of one event and advances the lock model.
  function automatic result_t door_event_result(input logic [FUNC_W-1:0] func,
                                                input logic [KEY_W-1:0]  key);
    result_t r;
    logic    match;
    int      k;
    r.motor_cmd = MOTOR_NONE;
    r.status    = ST_IGNORED;
    case (func)
      FUNC_KEY: begin
        if (lock_state == MODE_LOCKED) begin
          r.status = ST_LOCKED;
        end else if (lock_state == MODE_ENTRY && key != NO_KEY) begin
          typed_keys[typed_count] = key;
          if (typed_count < CODE_LEN - 1) begin
            typed_count = typed_count + 1'b1;
            r.status    = ST_KEY;
          end else begin
            typed_count = '0;
            match = 1'b1;
            for (k = 0; k < CODE_LEN; k++) begin
              if (typed_keys[k] != stored_code[k]) match = 1'b0;
            end
            if (match) begin
              r.motor_cmd = MOTOR_OPEN;
              r.status    = ST_RIGHT;
              lock_state  = MODE_DOOR;
              closed_seen = 1'b0;
            end else if (tries_avail > 1) begin
              tries_avail = tries_avail - 1'b1;
              r.status    = ST_WRONG;
            end else begin
              tries_avail = '0;
              lock_state  = MODE_LOCKED;
              r.status    = ST_LOCKED;
            end
          end
        end
      end
      FUNC_CLOSE_BTN: begin
        if (lock_state == MODE_DOOR && !closed_seen && opened_seen) begin
          r.motor_cmd = MOTOR_CLOSE;
          r.status    = ST_CLOSING;
          opened_seen = 1'b0;
          closing_on  = 1'b1;
        end
      end
      FUNC_CLOSE_LIM: begin
        if (open_hit && closing_on) begin
          r.motor_cmd = MOTOR_STOP;
          r.status    = ST_CLOSED;
          closed_seen = 1'b1;
          lock_state  = MODE_ENTRY;
          typed_count = '0;
          open_hit    = 1'b0;
          closing_on  = 1'b0;
        end
      end
      FUNC_OPEN_LIM: begin
        r.motor_cmd = MOTOR_STOP;
        r.status    = ST_OPENED;
        opened_seen = 1'b1;
        open_hit    = 1'b1;
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    r.tries_left   = tries_avail;
    r.keys_entered = typed_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    if (error_count < 50) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no item pending", 0, out_tdata);
      end else begin
        want = expected_results.pop_front();
        got  = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (got.motor_cmd != want.motor_cmd)
          report_mismatch("motor_cmd", want.motor_cmd, got.motor_cmd);
        if (got.status != want.status)
          report_mismatch("status", want.status, got.status);
        if (got.tries_left != want.tries_left)
          report_mismatch("tries_left", want.tries_left, got.tries_left);
        if (got.keys_entered != want.keys_entered)
          report_mismatch("keys_entered", want.keys_entered, got.keys_entered);
        if (out_tdata[OUT_D_W-1:$bits(result_t)] != '0)
          report_mismatch("tdata padding", 0, out_tdata[OUT_D_W-1:$bits(result_t)]);
      end
    end
  end

  // The receiver switches between stall styles, each held for a random stretch.
  always @(negedge clk) begin
    if (stall_left <= 0) begin
      stall_style = $urandom_range(STALL_NONE, STALL_LONG);
      stall_left  = $urandom_range(8, 40);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE:  out_tready <= 1'b1;
      STALL_COIN:  out_tready <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_tready <= ($urandom_range(0, 7) == 0);
      default:     out_tready <= (stall_left == 0);
    endcase
  end

  task automatic hold_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic drain_results();
    hold_input(1);
    while (expected_results.size() != 0) @(posedge clk);
    hold_input(2);
  endtask

  task automatic cfg_write(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == REG_TRY_LIMIT) begin
      tries_avail = value[TRIES_W-1:0];
    end else if (addr < NUM_CODE_REGS) begin
      stored_code[addr] = value;
    end
  endtask

  // Sends one event, with bursts, gaps and the occasional full drain.
  task automatic send_event(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key);
    result_t want;
    if (burst_left == 0) begin
      if ($urandom_range(0, 39) == 0) begin
        drain_results();
      end else if ($urandom_range(0, 2) != 0) begin
        hold_input($urandom_range(1, 6));
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    want = door_event_result(func, key);
    expected_results.push_back(want);
    if (want.status != ST_IGNORED) useful_items++;
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom_range(0, 254));
  endfunction

  task automatic send_code(input bit right);
    logic [KEY_W-1:0] keys [CODE_LEN];
    logic [KEY_W-1:0] alt;
    int               spot;
    foreach (keys[k]) keys[k] = stored_code[k];
    if (!right) begin
      if ($urandom_range(0, 3) == 0) begin
        foreach (keys[k]) keys[k] = any_key();
      end else begin
        spot = $urandom_range(0, CODE_LEN - 1);
        alt  = KEY_W'($urandom_range(0, 253));
        if (alt >= stored_code[spot]) alt = alt + 1'b1;
        keys[spot] = alt;
      end
    end
    foreach (keys[k]) send_event(FUNC_KEY, keys[k]);
  endtask

  // From door operation, the full handshake brings the lock back to code entry.
  task automatic return_to_entry();
    if (lock_state == MODE_DOOR) begin
      send_event(FUNC_OPEN_LIM, any_key());
      send_event(FUNC_CLOSE_BTN, any_key());
      send_event(FUNC_CLOSE_LIM, any_key());
    end
  endtask

  task automatic send_noise();
    logic [KEY_W-1:0] key;
    key = ($urandom_range(0, 11) == 0) ? NO_KEY : any_key();
    send_event(FUNC_W'($urandom_range(0, 3)), key);
  endtask

  task automatic test_reset_state();
    send_event(FUNC_KEY, NO_KEY);
    send_event(FUNC_CLOSE_BTN, 8'h00);
    send_event(FUNC_CLOSE_LIM, 8'hfe);
    send_code(1'b1);
    send_event(FUNC_KEY, 8'h5a);
    // Close button before the door has reached the open limit.
    send_event(FUNC_CLOSE_BTN, 8'h00);
    send_event(FUNC_OPEN_LIM, 8'h00);
    send_event(FUNC_CLOSE_BTN, 8'hff);
    send_event(FUNC_CLOSE_LIM, 8'h00);
    drain_results();
  endtask

  task automatic test_code_extremes();
    logic [KEY_W-1:0] code [NUM_CODE_REGS];
    code = '{8'hfe, 8'h00, 8'h80, 8'h7f, 8'h01};
    foreach (code[k]) cfg_write(CFG_A_W'(REG_CODE_KEY0 + k), code[k]);
    cfg_write(REG_TRY_LIMIT, 8'd15);
    send_code(1'b0);
    send_code(1'b1);
    return_to_entry();
    drain_results();
    foreach (code[k]) cfg_write(CFG_A_W'(REG_CODE_KEY0 + k), 8'hfe);
    // A single try left still lets the right code through.
    cfg_write(REG_TRY_LIMIT, 8'd1);
    send_code(1'b1);
    return_to_entry();
    drain_results();
  endtask

  task automatic random_step();
    int pick;
    int n;
    pick = $urandom_range(0, 9);
    case (lock_state)
      MODE_ENTRY: begin
        if (typed_count != 0 && pick < 6) begin
          // Finish a partly typed code with the stored keys.
          for (n = typed_count; n < CODE_LEN; n++) send_event(FUNC_KEY, stored_code[n]);
        end else if (pick < 4) begin
          send_code(1'b1);
        end else if (pick < 7) begin
          send_code(1'b0);
        end else if (pick < 8) begin
          n = $urandom_range(1, CODE_LEN - 1);
          repeat (n) send_event(FUNC_KEY, stored_code[$urandom_range(0, CODE_LEN - 1)]);
        end else begin
          send_noise();
        end
      end
      MODE_DOOR: begin
        if (pick < 7) begin
          send_event(FUNC_OPEN_LIM, any_key());
          if ($urandom_range(0, 3) == 0) send_noise();
          send_event(FUNC_CLOSE_BTN, any_key());
          if ($urandom_range(0, 3) == 0) send_noise();
          send_event(FUNC_CLOSE_LIM, any_key());
        end else begin
          send_noise();
        end
      end
      default: send_noise();
    endcase
  endtask

  task automatic test_random_traffic();
    int first;
    int phase_len;
    int k;
    while (useful_items < RANDOM_ITEMS) begin
      for (k = 0; k < NUM_CODE_REGS; k++) begin
        cfg_write(CFG_A_W'(REG_CODE_KEY0 + k), any_key());
      end
      cfg_write(REG_TRY_LIMIT,
                ($urandom_range(0, 3) == 0) ? 8'd15 : CFG_D_W'($urandom_range(2, 15)));
      first     = useful_items;
      phase_len = $urandom_range(60, 250);
      // Leave before a wrong code could lock the door for good.
      while (useful_items - first < phase_len && tries_avail > 1) random_step();
      drain_results();
    end
  endtask

  task automatic test_permanent_lock();
    int k;
    return_to_entry();
    drain_results();
    cfg_write(REG_TRY_LIMIT, 8'd15);
    while (typed_count != 0) send_event(FUNC_KEY, any_key());
    return_to_entry();
    drain_results();
    cfg_write(REG_TRY_LIMIT, 8'd3);
    repeat (3) send_code(1'b0);
    send_code(1'b1);
    send_event(FUNC_KEY, NO_KEY);
    send_event(FUNC_CLOSE_BTN, any_key());
    send_event(FUNC_OPEN_LIM, any_key());
    send_event(FUNC_CLOSE_BTN, any_key());
    send_event(FUNC_CLOSE_LIM, any_key());
    drain_results();
    // Reloading the tries does not release the lock.
    for (k = 0; k < NUM_CODE_REGS; k++) cfg_write(CFG_A_W'(REG_CODE_KEY0 + k), any_key());
    cfg_write(REG_TRY_LIMIT, 8'd9);
    send_code(1'b1);
    send_event(FUNC_OPEN_LIM, any_key());
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = FUNC_KEY;
    lock_state  = MODE_ENTRY;
    typed_count = '0;
    tries_avail = TRY_LIMIT_RST;
    closed_seen = 1'b0;
    opened_seen = 1'b0;
    open_hit    = 1'b0;
    closing_on  = 1'b0;
    foreach (stored_code[k]) stored_code[k] = '0;
    foreach (typed_keys[k]) typed_keys[k] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_code_extremes();
    test_random_traffic();
    test_permanent_lock();
    drain_results();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
